// File: src/aip_pkg.sv
`default_nettype none
package aip_pkg;

  // Default depth of the queue between the classifier and the parser core.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Largest magnitude that is kept; anything past it saturates.
  localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;

  // One classified text byte.
  typedef struct packed {
    logic       term;    // zero byte, ends the value
    logic       blank;   // space, TAB, LF, VT, FF, CR
    logic       plus;
    logic       minus;
    logic       zero;    // the character '0'
    logic       xch;     // 'x' or 'X'
    logic       dig_ok;  // decimal or hex digit of any case
    logic [3:0] digit;   // digit value when dig_ok
  } item_t;

  // Parse phase, one-hot.
  typedef enum logic [4:0] {
    PH_LEAD   = 5'b00001,
    PH_SIGN   = 5'b00010,
    PH_ZERO   = 5'b00100,
    PH_PREFIX = 5'b01000,
    PH_DIGITS = 5'b10000
  } phase_t;

  typedef enum logic [1:0] {
    RX_DEC = 2'd0,
    RX_OCT = 2'd1,
    RX_HEX = 2'd2
  } radix_t;

endpackage
`default_nettype wire

// File: src/auto_base_int32_text_parser_unit.sv
`default_nettype none
// Text-to-int32 parser with automatic base. Feed one text byte per input
// transaction; a zero byte terminates the value and produces exactly one
// output transaction carrying out_valid_res and the signed out_value (zero
// whenever out_valid_res is low). Accepted syntax: leading whitespace, an
// optional sign, then "0x"/"0X" and hex digits, a leading '0' and octal
// digits, or decimal digits; anything else, trailing text included, or a
// value outside int32 range makes the result invalid. Throughput is one
// byte per clock unless a terminator waits on a stalled result: the
// classifier register, the small queue and the parser core each move one
// transaction per cycle, and the core's shift-add of the magnitude sets
// that figure. A terminator passes the classifier register and the queue;
// the core registers its result. A result pending on out_stall holds
// back only the next terminator; ordinary bytes keep flowing into the core.
module auto_base_int32_text_parser_unit #(
  parameter int unsigned QUEUE_DEPTH = aip_pkg::QUEUE_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic [7:0]    in_ch,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic               out_valid_res,
  output logic signed [31:0] out_value
);

  // classifier -> queue
  logic           f_vld;
  logic           f_stall;
  aip_pkg::item_t f_item;

  // queue -> parser core
  logic           q_vld;
  logic           q_take;
  aip_pkg::item_t q_item;

  // Classify each byte and register it.
  aip_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_ch      (in_ch),
    .item_vld   (f_vld),
    .item       (f_item),
    .item_stall (f_stall)
  );

  // Decouple the classifier from the core so either side can stall.
  aip_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_vld   (f_vld),
    .wr_stall (f_stall),
    .wr_item  (f_item),
    .rd_vld   (q_vld),
    .rd_take  (q_take),
    .rd_item  (q_item)
  );

  // Advance the parse state and register the result on a terminator.
  aip_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .item_vld      (q_vld),
    .item_take     (q_take),
    .item          (q_item),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_valid_res (out_valid_res),
    .out_value     (out_value)
  );

endmodule
`default_nettype wire

// File: src/aip_front.sv
`default_nettype none
module aip_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic [7:0]    in_ch,
  output logic               item_vld,
  output aip_pkg::item_t     item,
  input  wire logic          item_stall
);

  logic           vld_r, vld_nxt;
  aip_pkg::item_t item_r;
  aip_pkg::item_t cls;
  logic           take;
  logic           push;

  always_comb begin
    cls        = '0;
    cls.term   = (in_ch == 8'h00);
    cls.blank  = (in_ch == 8'h20) || ((in_ch >= 8'h09) && (in_ch <= 8'h0D));
    cls.plus   = (in_ch == 8'h2B);
    cls.minus  = (in_ch == 8'h2D);
    cls.zero   = (in_ch == 8'h30);
    cls.xch    = (in_ch == 8'h78) || (in_ch == 8'h58);
    if ((in_ch >= 8'h30) && (in_ch <= 8'h39)) begin
      cls.dig_ok = 1'b1;
      cls.digit  = 4'(in_ch - 8'h30);
    end else if ((in_ch >= 8'h61) && (in_ch <= 8'h66)) begin
      cls.dig_ok = 1'b1;
      cls.digit  = 4'(in_ch - 8'h57);
    end else if ((in_ch >= 8'h41) && (in_ch <= 8'h46)) begin
      cls.dig_ok = 1'b1;
      cls.digit  = 4'(in_ch - 8'h37);
    end
  end

  assign push     = vld_r && !item_stall;
  assign in_stall = vld_r && item_stall;
  assign take     = in_valid && !in_stall;
  assign vld_nxt  = take || (vld_r && !push);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= cls;
    end
  end

  assign item_vld = vld_r;
  assign item     = item_r;

endmodule
`default_nettype wire

// File: src/aip_queue.sv
`default_nettype none
module aip_queue #(
  parameter int unsigned DEPTH = aip_pkg::QUEUE_DEPTH
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           wr_vld,
  output logic                wr_stall,
  input  wire aip_pkg::item_t wr_item,
  output logic                rd_vld,
  input  wire logic           rd_take,
  output aip_pkg::item_t      rd_item
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  aip_pkg::item_t  mem [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            push, pop;

  assign wr_stall = (cnt_r == CW'(DEPTH));
  assign rd_vld   = (cnt_r != '0);
  assign push     = wr_vld && !wr_stall;
  assign pop      = rd_vld && rd_take;
  assign rd_item  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_item;
    end
  end

endmodule
`default_nettype wire

// File: src/aip_back.sv
`default_nettype none
module aip_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            item_vld,
  output logic                 item_take,
  input  wire aip_pkg::item_t  item,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output logic                 out_valid_res,
  output logic signed [31:0]   out_value
);

  aip_pkg::phase_t phase_r, phase_nxt;
  aip_pkg::radix_t radix_r, radix_nxt;
  logic            neg_r, neg_nxt;
  logic [31:0]     mag_r, mag_nxt;
  logic            ovf_r, ovf_nxt;
  logic            bad_r, bad_nxt;
  logic            ov_r, ov_nxt;
  logic            res_r;
  logic [31:0]     val_r;
  logic            ok;
  logic [31:0]     val;
  logic            add;
  aip_pkg::radix_t add_rx;
  logic [32:0]     acc;
  logic            emit;

  // Multiply-accumulate by the radix, saturating at the limit.
  function automatic logic [32:0] mac(input logic [31:0] m, input aip_pkg::radix_t rx,
                                      input logic [3:0] d);
    logic [36:0] p;
    case (rx)
      aip_pkg::RX_OCT: p = {2'b00, m, 3'b000};
      aip_pkg::RX_HEX: p = {1'b0, m, 4'b0000};
      default:         p = {2'b00, m, 3'b000} + {4'b0000, m, 1'b0};
    endcase
    p = p + {33'd0, d};
    if (p > {5'd0, aip_pkg::MAG_LIMIT}) begin
      mac = {1'b1, aip_pkg::MAG_LIMIT};
    end else begin
      mac = {1'b0, p[31:0]};
    end
  endfunction

  assign item_take = item_vld && (!item.term || !ov_r || !out_stall);
  assign emit      = item_take && item.term;
  assign acc       = mac(mag_r, add_rx, item.digit);

  always_comb begin
    phase_nxt = phase_r;
    radix_nxt = radix_r;
    neg_nxt   = neg_r;
    mag_nxt   = mag_r;
    ovf_nxt   = ovf_r;
    bad_nxt   = bad_r;
    add       = 1'b0;
    add_rx    = radix_r;
    ok        = !bad_r && !ovf_r &&
                ((phase_r == aip_pkg::PH_ZERO) || (phase_r == aip_pkg::PH_DIGITS));
    val       = '0;
    if (ok) begin
      if (neg_r) begin
        val = 32'd0 - mag_r;
      end else if (mag_r[31]) begin
        ok = 1'b0;
      end else begin
        val = mag_r;
      end
    end

    if (item_take) begin
      if (item.term) begin
        phase_nxt = aip_pkg::PH_LEAD;
        radix_nxt = aip_pkg::RX_DEC;
        neg_nxt   = 1'b0;
        mag_nxt   = '0;
        ovf_nxt   = 1'b0;
        bad_nxt   = 1'b0;
      end else if (!bad_r) begin
        case (phase_r)
          aip_pkg::PH_LEAD, aip_pkg::PH_SIGN: begin
            if ((phase_r == aip_pkg::PH_LEAD) && item.blank) begin
              phase_nxt = phase_r;
            end else if ((phase_r == aip_pkg::PH_LEAD) && (item.plus || item.minus)) begin
              neg_nxt   = item.minus;
              phase_nxt = aip_pkg::PH_SIGN;
            end else if (item.zero) begin
              phase_nxt = aip_pkg::PH_ZERO;
            end else if (item.dig_ok && (item.digit <= 4'd9)) begin
              radix_nxt = aip_pkg::RX_DEC;
              add_rx    = aip_pkg::RX_DEC;
              add       = 1'b1;
              phase_nxt = aip_pkg::PH_DIGITS;
            end else begin
              bad_nxt = 1'b1;
            end
          end
          aip_pkg::PH_ZERO: begin
            if (item.xch) begin
              radix_nxt = aip_pkg::RX_HEX;
              phase_nxt = aip_pkg::PH_PREFIX;
            end else if (item.dig_ok && (item.digit < 4'd8)) begin
              radix_nxt = aip_pkg::RX_OCT;
              add_rx    = aip_pkg::RX_OCT;
              add       = 1'b1;
              phase_nxt = aip_pkg::PH_DIGITS;
            end else begin
              bad_nxt = 1'b1;
            end
          end
          aip_pkg::PH_PREFIX: begin
            if (item.dig_ok) begin
              add       = 1'b1;
              phase_nxt = aip_pkg::PH_DIGITS;
            end else begin
              bad_nxt = 1'b1;
            end
          end
          aip_pkg::PH_DIGITS: begin
            if (item.dig_ok &&
                ((radix_r == aip_pkg::RX_HEX) ||
                 ((radix_r == aip_pkg::RX_OCT) && (item.digit < 4'd8)) ||
                 ((radix_r == aip_pkg::RX_DEC) && (item.digit <= 4'd9)))) begin
              add = 1'b1;
            end else begin
              bad_nxt = 1'b1;
            end
          end
          default: bad_nxt = 1'b1;
        endcase
        if (add) begin
          mag_nxt = acc[31:0];
          ovf_nxt = ovf_r | acc[32];
        end
      end
    end
  end

  assign ov_nxt = emit || (ov_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= aip_pkg::PH_LEAD;
      radix_r <= aip_pkg::RX_DEC;
      neg_r   <= 1'b0;
      mag_r   <= '0;
      ovf_r   <= 1'b0;
      bad_r   <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      radix_r <= radix_nxt;
      neg_r   <= neg_nxt;
      mag_r   <= mag_nxt;
      ovf_r   <= ovf_nxt;
      bad_r   <= bad_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res_r <= ok;
      val_r <= val;
    end
  end

  assign out_valid     = ov_r;
  assign out_valid_res = res_r;
  assign out_value     = val_r;

endmodule
`default_nettype wire

// File: src/aip_checker.sv
`default_nettype none
module aip_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic [7:0]  in_ch,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        out_valid_res,
  input wire logic [31:0] out_value
);

  // Nothing comes out right after reset.
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output transaction right after reset");

  // An invalid result carries a zero value.
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_valid_res) |-> (out_value == 32'd0))
    else $error("invalid result with nonzero value");

  // A stalled result stays offered.
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> ($stable(out_value) && $stable(out_valid_res)))
    else $error("result payload changed while stalled");

endmodule

bind auto_base_int32_text_parser_unit aip_checker u_aip_checker (.*);
`default_nettype wire
